### src/scd_pkg.sv
// Shared types, constants and helpers for the stereo chorus delay.
package scd_pkg;

	localparam int DIG_W      = 4;
	localparam int MUL_DIGITS = 5;
	localparam int FRAC_DIGITS = 2;

	localparam logic [19:0] STEP_MIN    = 20'd4868;
	localparam logic [19:0] STEP_MAX    = 20'd778815;
	localparam logic [19:0] STEP_RESET  = 20'd49942;
	localparam logic [14:0] DEPTH_MAX   = 15'd20480;
	localparam logic [14:0] DEPTH_RESET = 15'd5632;
	localparam logic [17:0] BASE_DELAY_Q8 = 18'd56320;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_STEP   = 2'd1;
	localparam logic [1:0] REG_DEPTH  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADDR,
		ST_READ,
		ST_ILOAD,
		ST_INTERP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} lane_ctl_t;

	// Triangle offset by one: returns tri + 1.0 in Q2.16, range 0..131072
	function automatic logic [17:0] tri_biased(input logic [31:0] ph);
		logic [17:0] q;
		q = ph[31:14];
		if (q < 18'd65536)
			return {2'b01, q[15:0]};
		else if (q < 18'd196608)
			return 18'd196608 - q;
		else
			return q - 18'd196608;
	endfunction

endpackage

### src/scd_line_mem.sv
// Delay line storage: one write port and two registered read ports.
module scd_line_mem #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [15:0]       wdata,
	input  logic [AW-1:0]     raddr_a,
	input  logic [AW-1:0]     raddr_b,
	output logic [15:0]       rdata_a,
	output logic [15:0]       rdata_b
);
	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_a_q;
	logic [15:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;
endmodule

### src/scd_lfo_mul.sv
// Digit-serial multiply of depth by the biased triangle, one nibble per cycle while step is high.
module scd_lfo_mul (
	input  logic              clk,
	input  scd_pkg::lane_ctl_t ctl,
	input  logic [17:0]       tri_u,
	input  logic [14:0]       depth,
	output logic [31:0]       prod
);
	import scd_pkg::*;

	logic [19:0] u_sh_q;
	logic [31:0] acc_q;
	logic [18:0] pp;

	assign pp = 19'(depth) * 19'(u_sh_q[19:16]);

	// Most significant digit first: shift the partial sum and add
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			u_sh_q <= {2'b00, tri_u};
			acc_q  <= '0;
		end else if (ctl.step) begin
			u_sh_q <= {u_sh_q[15:0], 4'b0000};
			acc_q  <= {acc_q[27:0], 4'b0000} + {13'b0, pp};
		end
	end

	assign prod = acc_q;
endmodule

### src/scd_interp.sv
// Digit-serial linear interpolation between two adjacent line entries.
module scd_interp (
	input  logic               clk,
	input  scd_pkg::lane_ctl_t ctl,
	input  logic signed [15:0] a,
	input  logic signed [15:0] b,
	input  logic [7:0]         frac,
	output logic signed [15:0] y
);
	import scd_pkg::*;

	logic signed [15:0] a_q;
	logic signed [16:0] diff_q;
	logic [7:0]         f_sh_q;
	logic signed [24:0] acc_q;
	logic signed [21:0] pp;
	logic signed [24:0] pp_x;
	logic signed [25:0] sum;
	logic signed [25:0] sum_adj;

	assign pp   = 22'(diff_q) * 22'($signed({1'b0, f_sh_q[7:4]}));
	assign pp_x = pp;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q    <= a;
			diff_q <= 17'(b) - 17'(a);
			f_sh_q <= frac;
			acc_q  <= '0;
		end else if (ctl.step) begin
			f_sh_q <= {f_sh_q[3:0], 4'b0000};
			acc_q  <= $signed({acc_q[20:0], 4'b0000}) + pp_x;
		end
	end

	// a*256 + f*(b-a), then divide by 256 rounding toward zero
	assign sum     = $signed({{2{a_q[15]}}, a_q, 8'b0}) + 26'(acc_q);
	assign sum_adj = sum[25] ? (sum + 26'sd255) : sum;
	assign y       = sum_adj[23:8];
endmodule

### src/stereo_chorus_delay.sv
// Stereo chorus top level: control sequencer, registers and address generation.
// While enabled an accepted word passes the five-digit serial LFO multiply,
// address capture, the registered line read and the two-digit serial
// interpolation; while disabled it goes straight to a zero result. A new word
// is taken only after the last result is loaded into the output register.
// Reset clears control, write position and LFO phase, restores register
// defaults; line entries not yet written read as zero, so no clearing pass.
module stereo_chorus_delay #(
	parameter int LINE_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [15:0] sample_in,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] left_out,
	output logic [15:0] right_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import scd_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int PW = AW + 10;
	localparam logic [PW-1:0] SPAN = PW'(LINE_DEPTH * 256);
	localparam logic [AW-1:0] LAST = AW'(LINE_DEPTH - 1);

	state_t state_q, state_d;

	logic        enable_q;
	logic [19:0] step_q;
	logic [14:0] depth_q;
	logic [AW-1:0] wp_q;
	logic        wrapped_q;
	logic [31:0] phase_q;
	logic [2:0]  cnt_q;
	logic        zero_q;

	logic [AW-1:0] il_q, il2_q, ir_q, ir2_q;
	logic [7:0]    fl_q, fr_q;
	logic [3:0]    vld_q;

	logic        result_valid_q;
	logic [15:0] left_q, right_q;

	logic        accept;
	logic        mem_we;
	logic        out_load;
	lane_ctl_t   mul_ctl, int_ctl;
	logic [31:0] prod_l, prod_r;
	logic [15:0] rd_l, rd_l2, rd_r, rd_r2;
	logic [15:0] y_l, y_r;
	logic [AW+7:0] pos_l, pos_r;
	logic [AW-1:0] pl_i, pr_i;
	logic        cfg_wr;
	logic [19:0] wstep;
	logic [14:0] wdepth;

	// Read position in Q.8 for a lane, wrapped into the line span
	function automatic logic [AW+7:0] rd_pos(input logic [31:0] prod, input logic [14:0] dep,
			input logic [AW-1:0] wp);
		logic [17:0]          d;
		logic signed [PW-1:0] diff;
		logic signed [PW-1:0] wrap;
		d    = BASE_DELAY_Q8 + {2'b00, prod[31:16]} - {3'b000, dep};
		diff = $signed({2'b00, wp, 8'b0}) - $signed({{(PW-18){1'b0}}, d});
		wrap = diff + $signed(SPAN);
		if (diff[PW-1])
			return wrap[AW+7:0];
		else
			return diff[AW+7:0];
	endfunction

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		if (i == LAST)
			return '0;
		else
			return i + AW'(1);
	endfunction

	assign accept = sample_valid && !sample_stall;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		wstep = pwdata[19:0];
		if (wstep < STEP_MIN)
			wstep = STEP_MIN;
		if (wstep > STEP_MAX)
			wstep = STEP_MAX;
		wdepth = pwdata[14:0];
		if (wdepth > DEPTH_MAX)
			wdepth = DEPTH_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			step_q   <= STEP_RESET;
			depth_q  <= DEPTH_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ENABLE: enable_q <= pwdata[0];
				REG_STEP:   step_q   <= wstep;
				REG_DEPTH:  depth_q  <= wdepth;
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ENABLE: prdata = {31'b0, enable_q};
			REG_STEP:   prdata = {12'b0, step_q};
			REG_DEPTH:  prdata = {17'b0, depth_q};
			default:    prdata = '0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = enable_q ? ST_MUL : ST_DONE;
			end
			ST_MUL: begin
				if (cnt_q == 3'(MUL_DIGITS - 1))
					state_d = ST_ADDR;
			end
			ST_ADDR:  state_d = ST_READ;
			ST_READ:  state_d = ST_ILOAD;
			ST_ILOAD: state_d = ST_INTERP;
			ST_INTERP: begin
				if (cnt_q == 3'(FRAC_DIGITS - 1))
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!result_valid_q || !result_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		sample_stall = 1'b1;
		mem_we       = 1'b0;
		mul_ctl      = '0;
		int_ctl      = '0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				mem_we       = accept && enable_q;
				mul_ctl.load = accept;
			end
			ST_MUL:    mul_ctl.step = 1'b1;
			ST_ILOAD:  int_ctl.load = 1'b1;
			ST_INTERP: int_ctl.step = 1'b1;
			ST_DONE:   out_load = !result_valid_q || !result_stall;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			zero_q    <= 1'b0;
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			phase_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 3'd1;
			if (accept)
				zero_q <= !enable_q;
			// Advance write position and LFO once the word's result is out
			if (out_load && !zero_q) begin
				wp_q    <= next_idx(wp_q);
				phase_q <= phase_q + {12'b0, step_q};
				if (wp_q == LAST)
					wrapped_q <= 1'b1;
			end
		end
	end

	scd_lfo_mul u_mul_l (
		.clk   (clk),
		.ctl   (mul_ctl),
		.tri_u (tri_biased(phase_q)),
		.depth (depth_q),
		.prod  (prod_l)
	);

	scd_lfo_mul u_mul_r (
		.clk   (clk),
		.ctl   (mul_ctl),
		.tri_u (tri_biased(phase_q + 32'h8000_0000)),
		.depth (depth_q),
		.prod  (prod_r)
	);

	assign pos_l = rd_pos(prod_l, depth_q, wp_q);
	assign pos_r = rd_pos(prod_r, depth_q, wp_q);
	assign pl_i  = pos_l[AW+7:8];
	assign pr_i  = pos_r[AW+7:8];

	// Capture read indices; an entry past the write point is unwritten until wrap
	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			il_q  <= pl_i;
			il2_q <= next_idx(pl_i);
			fl_q  <= pos_l[7:0];
			ir_q  <= pr_i;
			ir2_q <= next_idx(pr_i);
			fr_q  <= pos_r[7:0];
			vld_q <= {wrapped_q || (next_idx(pr_i) <= wp_q),
			          wrapped_q || (pr_i <= wp_q),
			          wrapped_q || (next_idx(pl_i) <= wp_q),
			          wrapped_q || (pl_i <= wp_q)};
		end
	end

	scd_line_mem #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW)
	) u_line_l (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (wp_q),
		.wdata   (sample_in),
		.raddr_a (il_q),
		.raddr_b (il2_q),
		.rdata_a (rd_l),
		.rdata_b (rd_l2)
	);

	scd_line_mem #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW)
	) u_line_r (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (wp_q),
		.wdata   (sample_in),
		.raddr_a (ir_q),
		.raddr_b (ir2_q),
		.rdata_a (rd_r),
		.rdata_b (rd_r2)
	);

	scd_interp u_int_l (
		.clk  (clk),
		.ctl  (int_ctl),
		.a    (vld_q[0] ? $signed(rd_l) : 16'sd0),
		.b    (vld_q[1] ? $signed(rd_l2) : 16'sd0),
		.frac (fl_q),
		.y    (y_l)
	);

	scd_interp u_int_r (
		.clk  (clk),
		.ctl  (int_ctl),
		.a    (vld_q[2] ? $signed(rd_r) : 16'sd0),
		.b    (vld_q[3] ? $signed(rd_r2) : 16'sd0),
		.frac (fr_q),
		.y    (y_r)
	);

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_q  <= zero_q ? 16'd0 : y_l;
			right_q <= zero_q ? 16'd0 : y_r;
		end
	end

	assign result_valid = result_valid_q;
	assign left_out     = left_q;
	assign right_out    = right_q;
endmodule

### sim/tb_stereo_chorus_delay.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stereo chorus delay, predicted wet words against the block.
module tb_stereo_chorus_delay;
	import scd_pkg::*;

	localparam int LINE_DEPTH   = 512;
	localparam int LINE_SPAN_Q8 = LINE_DEPTH * 256;
	localparam int BASE_DLY_Q8  = 220 * 256;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
	} wet_pair_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        sample_valid = 1'b0;
	logic [15:0] sample_in    = '0;
	logic        result_stall = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [3:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic        sample_stall;
	logic        result_valid;
	logic [15:0] left_out;
	logic [15:0] right_out;
	logic [31:0] prdata;
	logic        pready;

	// chorus state and registers as the block should hold them
	logic signed [15:0]              line_mem [LINE_DEPTH];
	logic [$clog2(LINE_DEPTH)-1:0]   wr_pos;
	logic [31:0]                     lfo_ph;
	logic                            en_reg;
	logic [19:0]                     step_reg;
	logic [14:0]                     depth_reg;
	wet_pair_t                       wet_fifo[$];

	int   err_count   = 0;
	int   stall_pct   = 0;
	int   gap_max     = 0;
	int   burst_left  = 0;
	int   stall_left  = 0;
	logic stall_level = 1'b0;
	int   idle_cycles = 0;

	stereo_chorus_delay #(.LINE_DEPTH(LINE_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_in(sample_in),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.left_out(left_out),
		.right_out(right_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Interpolated read at 220 samples plus depth times the triangle behind wr_pos.
	function automatic logic [15:0] chorus_tap(input logic [31:0] ph);
		int     q;
		int     tri_v;
		int     i0;
		int     i1;
		int     f;
		int     acc;
		longint prod;
		longint dly;
		longint rpos;
		q = int'(ph >> 14);
		if (q < 65536)
			tri_v = q;
		else if (q < 196608)
			tri_v = 131072 - q;
		else
			tri_v = q - 262144;
		prod = longint'(depth_reg) * longint'(tri_v + 65536);
		dly  = BASE_DLY_Q8 + (prod >>> 16) - longint'(depth_reg);
		rpos = (longint'(wr_pos) * 256 + LINE_SPAN_Q8 - dly) % LINE_SPAN_Q8;
		i0   = int'(rpos >> 8);
		i1   = (i0 + 1) % LINE_DEPTH;
		f    = int'(rpos & 255);
		acc  = (256 - f) * int'(line_mem[i0]) + f * int'(line_mem[i1]);
		return 16'(acc / 256);
	endfunction

	function automatic logic [15:0] rand_sample();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			case ($urandom_range(0, 3))
				0: return 16'h7FFF;
				1: return 16'h8000;
				2: return 16'hFFFF;
				default: return 16'h0000;
			endcase
		end
		if (pick < 40)
			return 16'(int'($urandom_range(0, 511)) - 256);
		return 16'($urandom());
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%h, got 0x%h", name, want, got);
			err_count++;
		end
	endtask

	// Send one word in bursts with random gaps; predict its result once accepted.
	task automatic send_word(input logic [15:0] x);
		int        gap;
		wet_pair_t w;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, gap_max);
			repeat (gap) begin
				@(negedge clk);
				sample_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		sample_valid <= 1'b1;
		sample_in    <= x;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		if (!en_reg) begin
			w = '0;
		end else begin
			line_mem[wr_pos] = x;
			w.left  = chorus_tap(lfo_ph);
			w.right = chorus_tap(lfo_ph + 32'h8000_0000);
			wr_pos  = wr_pos + 1'b1;
			lfo_ph  = lfo_ph + step_reg;
		end
		wet_fifo.push_back(w);
	endtask

	// Drop valid and hold until every expected word has come back.
	task automatic wait_idle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (wet_fifo.size() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
		logic [19:0] s;
		logic [14:0] d;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_ENABLE: en_reg = data[0];
			REG_STEP: begin
				s = data[19:0];
				step_reg = (s < STEP_MIN) ? STEP_MIN : (s > STEP_MAX) ? STEP_MAX : s;
			end
			REG_DEPTH: begin
				d = data[14:0];
				depth_reg = (d > DEPTH_MAX) ? DEPTH_MAX : d;
			end
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_read(input logic [1:0] idx);
		logic [31:0] want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_ENABLE: want = {31'b0, en_reg};
			REG_STEP:   want = {12'b0, step_reg};
			REG_DEPTH:  want = {17'b0, depth_reg};
			default:    want = '0;
		endcase
		check_field("prdata", want, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] step_w, input logic [31:0] depth_w,
			input int count, input int stall_p, input int gap_p);
		wait_idle();
		reg_write(REG_STEP, step_w);
		reg_write(REG_DEPTH, depth_w);
		reg_read(REG_STEP);
		reg_read(REG_DEPTH);
		stall_pct = stall_p;
		gap_max   = gap_p;
		repeat (count)
			send_word(rand_sample());
	endtask

	task automatic test_register_file();
		reg_read(REG_ENABLE);
		reg_read(REG_STEP);
		reg_read(REG_DEPTH);
		reg_write(REG_STEP, 32'd0);
		reg_read(REG_STEP);
		reg_write(REG_STEP, 32'hFFFF_FFFF);
		reg_read(REG_STEP);
		reg_write(REG_STEP, 32'hFFF4_93E0);
		reg_read(REG_STEP);
		reg_write(REG_DEPTH, 32'h0000_7FFF);
		reg_read(REG_DEPTH);
		reg_write(REG_DEPTH, 32'hFFFF_0000);
		reg_read(REG_DEPTH);
		reg_write(REG_ENABLE, 32'hFFFF_FFFE);
		reg_read(REG_ENABLE);
		reg_write(REG_ENABLE, 32'd1);
		reg_read(REG_ENABLE);
		reg_write(REG_STEP, {12'b0, STEP_MAX});
		reg_write(REG_DEPTH, {17'b0, DEPTH_MAX});
		// a write to an unmapped address must leave every register alone
		reg_write(REG_UNUSED, 32'hFFFF_FFFF);
		reg_read(REG_ENABLE);
		reg_read(REG_STEP);
		reg_read(REG_DEPTH);
	endtask

	task automatic test_sample_extremes();
		logic [15:0] words[16];
		words = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE,
			16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h8000, 16'h0000};
		stall_pct = 0;
		gap_max   = 0;
		foreach (words[k])
			send_word(words[k]);
	endtask

	task automatic test_disabled_hold();
		wait_idle();
		reg_write(REG_ENABLE, 32'hFFFF_FFFE);
		reg_read(REG_ENABLE);
		stall_pct = 30;
		gap_max   = 5;
		send_word(16'h7FFF);
		send_word(16'h8000);
		repeat (6)
			send_word(rand_sample());
		wait_idle();
		reg_write(REG_ENABLE, 32'd1);
		reg_read(REG_ENABLE);
	endtask

	task automatic test_lfo_extremes();
		run_phase({12'b0, STEP_RESET}, {17'b0, DEPTH_RESET}, 60, 20, 3);
		run_phase({12'b0, STEP_MIN}, 32'd0, 60, 0, 0);
		run_phase({12'b0, STEP_MIN}, {17'b0, DEPTH_MAX}, 40, 60, 10);
	endtask

	task automatic test_random_settings();
		repeat (4)
			run_phase($urandom(), $urandom(), 25, $urandom_range(0, 80), $urandom_range(0, 12));
	endtask

	// Sweep the taps at the fastest rate and full depth under two stall patterns.
	task automatic test_full_swing();
		run_phase({12'b0, STEP_MAX}, {17'b0, DEPTH_MAX}, 560, 40, 6);
		run_phase({12'b0, STEP_MAX}, {17'b0, DEPTH_MAX}, 560, 70, 20);
	endtask

	// Receiver stall pattern: random runs, each stalled or free.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_left  = $urandom_range(1, 20);
			stall_level = ($urandom_range(0, 99) < stall_pct);
		end
		stall_left--;
		result_stall <= stall_level;
	end

	always @(posedge clk) begin : wet_check
		wet_pair_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (wet_fifo.size() == 0) begin
				$error("left_out/right_out: no word expected, got 0x%h / 0x%h",
					left_out, right_out);
				err_count++;
			end else begin
				want = wet_fifo.pop_front();
				check_field("left_out", {16'b0, want.left}, {16'b0, left_out});
				check_field("right_out", {16'b0, want.right}, {16'b0, right_out});
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (psel && penable && pready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : main
		for (int k = 0; k < LINE_DEPTH; k++)
			line_mem[k] = '0;
		wr_pos    = '0;
		lfo_ph    = '0;
		en_reg    = 1'b0;
		step_reg  = STEP_RESET;
		depth_reg = DEPTH_RESET;
		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;

		test_register_file();
		test_sample_extremes();
		test_disabled_hold();
		test_lfo_extremes();
		test_random_settings();
		test_full_swing();

		wait_idle();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (wet_fifo.size() != 0) begin
			$error("left_out/right_out: %0d expected words never arrived", wet_fifo.size());
			err_count++;
		end
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
